>>> src/assert_macros.svh
// Assertion macros shared by the frame buffer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent true implies consequent true in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/pfb_pkg.sv
// Package for the page frame buffer: geometry, command codes and shared types.
// No dependencies; imported by every module of the block.
package pfb_pkg;

   localparam int WIDTH       = 128;
   localparam int HEIGHT      = 64;
   localparam int PAGES       = (HEIGHT + 7) / 8;
   localparam int STORE_SIZE  = WIDTH * PAGES;
   localparam int ADDR_W      = $clog2(STORE_SIZE);
   localparam int COL_W       = $clog2(WIDTH);
   localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CONTRAST_W  = 6;

   localparam logic [7:0] WIDTH_LIMIT  = 8'(WIDTH);
   localparam logic [7:0] HEIGHT_LIMIT = 8'(HEIGHT);

   localparam logic [7:0] CTL_PAGE_BASE   = 8'hB0;
   localparam logic [7:0] CTL_COL_HI_BASE = 8'h10;
   localparam logic [7:0] CTL_COL_LO_MASK = 8'h0F;
   localparam logic [7:0] CTL_INVERT_BASE = 8'hA6;
   localparam logic [7:0] CTL_CONTRAST    = 8'h81;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL     = 3'd0,
      CMD_READ_PIXEL    = 3'd1,
      CMD_START_FLUSH   = 3'd2,
      CMD_PULL          = 3'd3,
      CMD_SET_INVERT    = 3'd4,
      CMD_TOGGLE_INVERT = 3'd5,
      CMD_CONTRAST      = 3'd6,
      CMD_NOP           = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      OV_NAND = 2'd0,
      OV_OR   = 2'd1,
      OV_XOR  = 2'd2,
      OV_KEEP = 2'd3
   } overlay_type;

   // Classified item as it travels from the front end to the back end.
   typedef struct packed {
      cmd_type                 cmd;
      logic [ADDR_W-1:0]       addr;
      logic [2:0]              bit_sel;
      logic                    in_range;
      logic                    value;
      overlay_type             overlay;
      logic                    invert_on;
      logic [CONTRAST_W-1:0]   contrast;
      logic [COL_W-1:0]        first_col;
      logic [COL_W-1:0]        last_col;
      logic [PAGE_W-1:0]       first_page;
      logic [PAGE_W-1:0]       last_page;
      logic                    span_ok;
   } item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       is_data;
      logic       pixel;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic [COL_W-1:0] c,
                                                    input logic [PAGE_W-1:0] p);
      store_addr = ADDR_W'(int'(c) * PAGES + int'(p));
   endfunction

endpackage

>>> src/pfb_if.sv
// Valid/ready channel interfaces for the request and response sides.
// No dependencies beyond the language itself.
interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] col;
   logic [7:0] row;
   logic [7:0] end_col;
   logic [7:0] end_row;
   logic       value;
   logic [1:0] overlay;
   logic       invert_on;
   logic [7:0] contrast;

   modport source (output valid, cmd, col, row, end_col, end_row, value, overlay,
                   invert_on, contrast, input ready);
   modport sink (input valid, cmd, col, row, end_col, end_row, value, overlay,
                 invert_on, contrast, output ready);
endinterface

interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic       is_data;
   logic       pixel;
   logic       last;

   modport source (output valid, kind, out_byte, is_data, pixel, last, input ready);
   modport sink (input valid, kind, out_byte, is_data, pixel, last, output ready);
endinterface

>>> src/pfb_queue.sv
// Short item queue between the front and back ends of the frame buffer.
// Depends on pfb_pkg for the item type and depth.
module pfb_queue import pfb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type status
);

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> src/pfb_front.sv
// Front end: accepts requests, checks pixel ranges, clamps flush bounds
// and forms store addresses. Depends on pfb_pkg and pfb_req_if.
module pfb_front import pfb_pkg::*; (
   pfb_req_if.sink          req,
   input  queue_status_type q_status,
   input  back_status_type  b_status,
   output logic             push,
   output item_type         push_item
);

   logic [7:0] col_clamped;
   logic [7:0] end_col_clamped;
   logic [7:0] row_clamped;
   logic [7:0] end_row_clamped;
   logic       pix_in_range;

   assign req.ready = !q_status.full && !b_status.clearing;
   assign push      = req.valid && req.ready;

   always_comb begin
      col_clamped     = (req.col >= WIDTH_LIMIT) ? WIDTH_LIMIT - 8'd1 : req.col;
      end_col_clamped = (req.end_col >= WIDTH_LIMIT) ? WIDTH_LIMIT - 8'd1 : req.end_col;
      row_clamped     = (req.row >= HEIGHT_LIMIT) ? HEIGHT_LIMIT - 8'd1 : req.row;
      end_row_clamped = (req.end_row >= HEIGHT_LIMIT) ? HEIGHT_LIMIT - 8'd1 : req.end_row;
      pix_in_range    = (req.col < WIDTH_LIMIT) && (req.row < HEIGHT_LIMIT);

      push_item.cmd        = cmd_type'(req.cmd);
      // The clamped coordinates keep the address inside the store even when
      // the pixel itself is out of range; in_range then masks the effect.
      push_item.addr       = store_addr(COL_W'(col_clamped), PAGE_W'(row_clamped >> 3));
      push_item.bit_sel    = req.row[2:0];
      push_item.in_range   = pix_in_range;
      push_item.value      = req.value;
      push_item.overlay    = overlay_type'(req.overlay);
      push_item.invert_on  = req.invert_on;
      push_item.contrast   = req.contrast[CONTRAST_W-1:0];
      push_item.first_col  = COL_W'(col_clamped);
      push_item.last_col   = COL_W'(end_col_clamped);
      push_item.first_page = PAGE_W'(row_clamped >> 3);
      push_item.last_page  = PAGE_W'(end_row_clamped >> 3);
      push_item.span_ok    = (row_clamped >> 3) <= (end_row_clamped >> 3);
   end

endmodule

>>> src/pfb_back.sv
// Back end: owns the frame store, the flush sequencer, the invert flag and
// the response register. Depends on pfb_pkg and pfb_rsp_if.
module pfb_back import pfb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  item_type         head,
   input  queue_status_type q_status,
   output logic             pop,
   output back_status_type  b_status,
   pfb_rsp_if.source        rsp
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_FETCH  = 4'b0010,
      ST_EXEC   = 4'b0100,
      ST_SECOND = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PH_PAGE   = 2'd0,
      PH_COL_HI = 2'd1,
      PH_COL_LO = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   item_type          op_ff, op_in;
   logic [7:0]        rd_data_ff;
   logic [7:0]        store [STORE_SIZE];

   logic              active_ff, active_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] last_page_ff, last_page_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  first_ff, first_in;
   logic [COL_W-1:0]  lastc_ff, lastc_in;
   phase_type         phase_ff, phase_in;
   logic              invert_ff, invert_in;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic              out_free;
   logic              out_load;
   rsp_payload_type   out_data;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      logic [7:0] mask;
      logic       page_done;
      logic       toggled;

      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      op_in        = op_ff;
      active_in    = active_ff;
      page_in      = page_ff;
      last_page_in = last_page_ff;
      col_in       = col_ff;
      first_in     = first_ff;
      lastc_in     = lastc_ff;
      phase_in     = phase_ff;
      invert_in    = invert_ff;
      mem_we       = 1'b0;
      mem_waddr    = op_ff.addr;
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = head.addr;
      pop          = 1'b0;
      out_load     = 1'b0;
      out_data     = '0;
      mask         = 8'(1) << op_ff.bit_sel;
      page_done    = 1'b0;
      toggled      = ~invert_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = 8'h00;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(STORE_SIZE - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               op_in    = head;
               mem_re   = 1'b1;
               // A pull reads the byte at the flush cursor; it is used only
               // if the sequencer is in its data phase.
               if (head.cmd == CMD_PULL) begin
                  mem_raddr = store_addr(col_ff, page_ff);
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff.cmd)
               CMD_SET_PIXEL: begin
                  mem_we = op_ff.in_range;
                  if (op_ff.overlay == OV_NAND || !op_ff.value) begin
                     mem_wdata = rd_data_ff & ~mask;
                  end else if (op_ff.overlay == OV_OR) begin
                     mem_wdata = rd_data_ff | mask;
                  end else if (op_ff.overlay == OV_XOR) begin
                     mem_wdata = rd_data_ff ^ mask;
                  end else begin
                     mem_wdata = rd_data_ff;
                  end
                  state_in = ST_FETCH;
               end
               CMD_READ_PIXEL: begin
                  if (out_free) begin
                     out_load       = 1'b1;
                     out_data.kind  = KIND_PIXEL;
                     out_data.pixel = op_ff.in_range && rd_data_ff[op_ff.bit_sel];
                     state_in       = ST_FETCH;
                  end
               end
               CMD_START_FLUSH: begin
                  first_in     = op_ff.first_col;
                  lastc_in     = op_ff.last_col;
                  col_in       = op_ff.first_col;
                  page_in      = op_ff.first_page;
                  last_page_in = op_ff.last_page;
                  phase_in     = PH_PAGE;
                  active_in    = op_ff.span_ok;
                  state_in     = ST_FETCH;
               end
               CMD_PULL: begin
                  if (!active_ff) begin
                     state_in = ST_FETCH;
                  end else if (out_free) begin
                     out_load      = 1'b1;
                     out_data.kind = KIND_BYTE;
                     unique case (phase_ff)
                        PH_PAGE: begin
                           out_data.out_byte = CTL_PAGE_BASE | 8'(page_ff);
                           phase_in          = PH_COL_HI;
                        end
                        PH_COL_HI: begin
                           out_data.out_byte = CTL_COL_HI_BASE | 8'(first_ff >> 4);
                           phase_in          = PH_COL_LO;
                        end
                        PH_COL_LO: begin
                           out_data.out_byte = 8'(first_ff) & CTL_COL_LO_MASK;
                           if (first_ff <= lastc_ff) begin
                              col_in   = first_ff;
                              phase_in = PH_DATA;
                           end else begin
                              page_done = 1'b1;
                           end
                        end
                        PH_DATA: begin
                           out_data.out_byte = rd_data_ff;
                           out_data.is_data  = 1'b1;
                           if (col_ff >= lastc_ff) begin
                              page_done = 1'b1;
                           end else begin
                              col_in = col_ff + COL_W'(1);
                           end
                        end
                        default: begin
                           phase_in = PH_PAGE;
                        end
                     endcase
                     if (page_done) begin
                        phase_in = PH_PAGE;
                        if (page_ff >= last_page_ff) begin
                           active_in     = 1'b0;
                           out_data.last = 1'b1;
                        end else begin
                           page_in = page_ff + PAGE_W'(1);
                        end
                     end
                     state_in = ST_FETCH;
                  end
               end
               CMD_SET_INVERT: begin
                  if (out_free) begin
                     invert_in         = op_ff.invert_on;
                     out_load          = 1'b1;
                     out_data.kind     = KIND_BYTE;
                     out_data.out_byte = CTL_INVERT_BASE | 8'(op_ff.invert_on);
                     out_data.last     = 1'b1;
                     state_in          = ST_FETCH;
                  end
               end
               CMD_TOGGLE_INVERT: begin
                  if (out_free) begin
                     invert_in         = toggled;
                     out_load          = 1'b1;
                     out_data.kind     = KIND_BYTE;
                     out_data.out_byte = CTL_INVERT_BASE | 8'(toggled);
                     out_data.last     = 1'b1;
                     state_in          = ST_FETCH;
                  end
               end
               CMD_CONTRAST: begin
                  if (out_free) begin
                     out_load          = 1'b1;
                     out_data.kind     = KIND_BYTE;
                     out_data.out_byte = CTL_CONTRAST;
                     state_in          = ST_SECOND;
                  end
               end
               default: begin
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_SECOND: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_data.kind     = KIND_BYTE;
               out_data.out_byte = 8'(op_ff.contrast);
               out_data.last     = 1'b1;
               state_in          = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         active_ff    <= 1'b0;
         page_ff      <= '0;
         last_page_ff <= '0;
         col_ff       <= '0;
         first_ff     <= '0;
         lastc_ff     <= '0;
         phase_ff     <= PH_PAGE;
         invert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         active_ff    <= active_in;
         page_ff      <= page_in;
         last_page_ff <= last_page_in;
         col_ff       <= col_in;
         first_ff     <= first_in;
         lastc_ff     <= lastc_in;
         phase_ff     <= phase_in;
         invert_ff    <= invert_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   // Single write port and single registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store[mem_raddr];
      end
   end

   assign b_status.clearing = (state_ff == ST_CLEAR);

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_data_ff.kind;
   assign rsp.out_byte = rsp_data_ff.out_byte;
   assign rsp.is_data  = rsp_data_ff.is_data;
   assign rsp.pixel    = rsp_data_ff.pixel;
   assign rsp.last     = rsp_data_ff.last;

endmodule

>>> src/page_frame_buffer_flush_top.sv
// A request passes the queue, then the fetch state (frame store read), then the
// execute state (execute or write back); responses leave from a registered output.
// Contrast takes a second state for its value byte; the store read is registered.
// A two-entry queue lets requests arrive while the back end or response side stalls.
// Reset is synchronous; afterwards the store, STORE_SIZE (1024) bytes, is cleared
// one byte a cycle, during which req_ch.ready stays low.
`include "assert_macros.svh"

module page_frame_buffer_flush_top import pfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfb_req_if.sink    req_ch,
   pfb_rsp_if.source  rsp_ch
);

   queue_status_type q_status;
   back_status_type  b_status;
   logic             q_push;
   logic             q_pop;
   item_type         push_item;
   item_type         head;

   pfb_front u_front (
      .req       (req_ch),
      .q_status  (q_status),
      .b_status  (b_status),
      .push      (q_push),
      .push_item (push_item)
   );

   pfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   pfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (q_pop),
      .b_status (b_status),
      .rsp      (rsp_ch)
   );

   `ASSERT_IMPL(a_no_transfer_while_clearing, clock, reset, b_status.clearing, !req_ch.ready)
   `ASSERT_IMPL(a_queue_no_overflow, clock, reset, q_push, !q_status.full || q_pop)
   `ASSERT_IMPL(a_queue_no_underflow, clock, reset, q_pop, !q_status.empty)
   `ASSERT_NEXT(a_clear_runs_once, clock, reset, !b_status.clearing, !b_status.clearing)
   `ASSERT_IMPL(a_readback_clean, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_PIXEL,
                rsp_ch.out_byte == 8'h00 && !rsp_ch.is_data && !rsp_ch.last)

endmodule
